// ===== hdl/sbp_pkg.sv =====
// Shared constants, codes and control types of the store-bypass predictor table.
`default_nettype none
package sbp_pkg;

	// Table depth; a power of two, so the entry index is the low PC bits.
	localparam int ENTRIES    = 1024;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int WAIT_W     = 6;
	localparam int VIOL_W     = 2;
	localparam int ENTRY_W    = WAIT_W + VIOL_W;
	localparam int PC_W       = 64;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_PREDICT   = 2'd0,
		OP_VIOLATION = 2'd1,
		OP_RESOLVE   = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WAIT_MAX    = 3'd0,
		CFG_VIOL_MAX    = 3'd1,
		CFG_WAIT_SET    = 3'd2,
		CFG_WAIT_INC    = 3'd3,
		CFG_FORGIVE     = 3'd4,
		CFG_FORCE_BLOCK = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic wr_en;
		logic clr_wr;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear_op;
		logic sweep_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/sbp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module sbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sbp_dp.sv =====
// Datapath: request capture, configuration registers, counter update, table and result register.
`default_nettype none
module sbp_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire sbp_pkg::ctrl_cmd_t               cmd,
	output sbp_pkg::dp_status_t                   status,
	input  wire logic [sbp_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire logic [sbp_pkg::OP_W-1:0]         s_tuser,
	input  wire logic                             cfg_valid,
	input  wire logic [sbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic      [sbp_pkg::M_TDATA_W-1:0]    m_tdata
);

	// captured request
	sbp_pkg::op_t                  op_q;
	logic [sbp_pkg::IDX_W-1:0]     idx_q;
	logic                          is_load_q;
	logic                          aliased_q;

	// clearing sweep address
	logic [sbp_pkg::IDX_W-1:0]     sweep_q;

	// configuration
	logic [sbp_pkg::WAIT_W-1:0]    wait_max_q;
	logic [sbp_pkg::VIOL_W-1:0]    viol_max_q;
	logic [sbp_pkg::WAIT_W-1:0]    wait_set_q;
	logic [sbp_pkg::WAIT_W-1:0]    wait_inc_q;
	logic                          forgive_q;
	logic                          force_block_q;

	// result register
	logic                          must_wait_q;
	logic [sbp_pkg::WAIT_W-1:0]    wait_out_q;
	logic [sbp_pkg::VIOL_W-1:0]    viol_out_q;

	logic [sbp_pkg::ENTRY_W-1:0]   rd_data;
	logic [sbp_pkg::ENTRY_W-1:0]   wr_data;
	logic [sbp_pkg::IDX_W-1:0]     wr_addr;
	logic [sbp_pkg::WAIT_W-1:0]    w_cur;
	logic [sbp_pkg::VIOL_W-1:0]    v_cur;
	logic [sbp_pkg::WAIT_W-1:0]    w_new;
	logic [sbp_pkg::VIOL_W-1:0]    v_new;
	logic [sbp_pkg::VIOL_W-1:0]    v_bump;
	logic [sbp_pkg::WAIT_W:0]      wait_sum;
	logic                          must_wait;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= sbp_pkg::op_t'(s_tuser);
			idx_q     <= s_tdata[sbp_pkg::IDX_W-1:0];
			is_load_q <= s_tdata[sbp_pkg::PC_W];
			aliased_q <= s_tdata[sbp_pkg::PC_W+1];
		end
		if (cmd.load_out) begin
			must_wait_q <= must_wait;
			wait_out_q  <= w_new;
			viol_out_q  <= v_new;
		end
	end

	// sweep wraps back to zero after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clr_wr) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_max_q    <= 6'd63;
			viol_max_q    <= 2'd3;
			wait_set_q    <= 6'd15;
			wait_inc_q    <= 6'd1;
			forgive_q     <= 1'b0;
			force_block_q <= 1'b0;
		end else if (cfg_valid) begin
			case (sbp_pkg::cfg_reg_t'(cfg_index))
				sbp_pkg::CFG_WAIT_MAX:    wait_max_q    <= cfg_data;
				sbp_pkg::CFG_VIOL_MAX:    viol_max_q    <= cfg_data[sbp_pkg::VIOL_W-1:0];
				sbp_pkg::CFG_WAIT_SET:    wait_set_q    <= cfg_data;
				sbp_pkg::CFG_WAIT_INC:    wait_inc_q    <= cfg_data;
				sbp_pkg::CFG_FORGIVE:     forgive_q     <= cfg_data[0];
				sbp_pkg::CFG_FORCE_BLOCK: force_block_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign w_cur    = rd_data[sbp_pkg::WAIT_W-1:0];
	assign v_cur    = rd_data[sbp_pkg::ENTRY_W-1:sbp_pkg::WAIT_W];
	assign v_bump   = (v_cur < viol_max_q) ? v_cur + 2'd1 : v_cur;
	assign wait_sum = {1'b0, w_cur} + {1'b0, wait_inc_q};

	always_comb begin
		must_wait = 1'b0;
		w_new     = w_cur;
		v_new     = v_cur;
		case (op_q)
			sbp_pkg::OP_PREDICT: begin
				must_wait = is_load_q && (force_block_q || (w_cur != '0));
			end
			sbp_pkg::OP_VIOLATION: begin
				v_new = v_bump;
				w_new = (v_bump >= viol_max_q) ? wait_set_q : '0;
			end
			sbp_pkg::OP_RESOLVE: begin
				if (aliased_q) begin
					// saturate the unwrapped sum at the ceiling
					w_new = (wait_sum > {1'b0, wait_max_q}) ? wait_max_q
						: wait_sum[sbp_pkg::WAIT_W-1:0];
				end else if (w_cur != '0) begin
					w_new = w_cur - 1'b1;
					if (forgive_q && (w_cur == 6'd1)) begin
						v_new = '0;
					end
				end
			end
			sbp_pkg::OP_CLEAR: begin
				w_new = '0;
				v_new = '0;
			end
			default: ;
		endcase
	end

	assign wr_addr = cmd.clr_wr ? sweep_q : idx_q;
	assign wr_data = cmd.clr_wr ? '0 : {v_new, w_new};

	sbp_ram #(
		.WIDTH(sbp_pkg::ENTRY_W),
		.DEPTH(sbp_pkg::ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.wr_en || cmd.clr_wr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (s_tdata[sbp_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign status.is_clear_op = (op_q == sbp_pkg::OP_CLEAR);
	assign status.sweep_last  = (sweep_q == sbp_pkg::IDX_W'(sbp_pkg::ENTRIES - 1));

	assign m_tdata = {7'b0, viol_out_q, wait_out_q, must_wait_q};

endmodule
`default_nettype wire

// ===== hdl/sbp_ctrl.sv =====
// Controller: sequences table clearing, request read, update and the result handshake.
`default_nettype none
module sbp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	input  wire sbp_pkg::dp_status_t status,
	output sbp_pkg::ctrl_cmd_t       cmd
);

	sbp_pkg::state_t state_q;
	sbp_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			sbp_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.sweep_last) begin
					state_nxt = sbp_pkg::ST_IDLE;
				end
			end
			sbp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					cmd.rd_en   = 1'b1;
					state_nxt   = sbp_pkg::ST_CALC;
				end
			end
			sbp_pkg::ST_CALC: begin
				// hold the update until the result register can take it
				if (out_free) begin
					cmd.load_out = 1'b1;
					if (status.is_clear_op) begin
						state_nxt = sbp_pkg::ST_CLEAR;
					end else begin
						cmd.wr_en = 1'b1;
						state_nxt = sbp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = sbp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result register overwritten while holding an untaken result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("computed result not presented");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == sbp_pkg::ST_CALC && !s_tready))
		else $error("accepted request not followed by its update cycle");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> (!s_tready && !cmd.wr_en && !cmd.rd_en))
		else $error("table access during clearing sweep");

endmodule
`default_nettype wire

// ===== hdl/store_bypass_predictor_table_top.sv =====
// Top level of the store-bypass predictor table.
//
// Requests enter on the s_ group: s_tuser carries the operation (predict, violation,
// resolve, clear) and s_tdata the load PC, is_load and aliased. Each request gives
// exactly one result on the m_ group: must_wait, wait_count and violation_count of the
// addressed entry after the update. The low PC bits select one of 1024 entries.
// A request is handled in the IDLE and CALC states: the table read on the accept edge,
// then in CALC the update and the load of the result register behind m_tvalid.
// No new request is taken before the block is back in IDLE with that update done.
// A clear request, and reset, run a sweep that zeroes the table one entry per cycle,
// during which s_tready is low. After reset the block first accepts requests once that
// sweep ends. Configuration writes are taken on any cycle (cfg_ready is always high)
// and go to registers at once; write them only while idle.
// When the receiver stalls, the result holds in the output register; one more request
// may be accepted and read, and its update waits until the result register is free.
`default_nettype none
module store_bypass_predictor_table_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [63:0] load_pc, [64] is_load, [65] aliased, [71:66] zero
	input  wire logic [sbp_pkg::S_TDATA_W-1:0]    s_tdata,
	// [1:0] operation
	input  wire logic [sbp_pkg::OP_W-1:0]         s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [0] must_wait, [6:1] wait_count, [8:7] violation_count, [15:9] zero
	output logic      [sbp_pkg::M_TDATA_W-1:0]    m_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sbp_pkg::ctrl_cmd_t  cmd;
	sbp_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	sbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sbp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// ===== test/sbp_checker.sv =====
// Checker for the store-bypass predictor table: predicts each request's result and compares.
`timescale 1ns / 100ps
module sbp_checker
	import sbp_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_tready,
	input  wire logic [S_TDATA_W-1:0]    s_tdata,
	input  wire logic [OP_W-1:0]         s_tuser,
	input  wire logic                    m_tvalid,
	input  wire logic                    m_tready,
	input  wire logic [M_TDATA_W-1:0]    m_tdata,
	input  wire logic                    cfg_valid,
	input  wire logic                    cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	output int                           outstanding,
	output int                           fail_count
);

	typedef struct packed {
		logic              must_wait;
		logic [WAIT_W-1:0] wait_count;
		logic [VIOL_W-1:0] viol_count;
	} entry_report_t;

	logic [WAIT_W-1:0] wait_tbl [ENTRIES];
	logic [VIOL_W-1:0] viol_tbl [ENTRIES];

	logic [WAIT_W-1:0] wait_max;
	logic [VIOL_W-1:0] viol_max;
	logic [WAIT_W-1:0] wait_set;
	logic [WAIT_W-1:0] wait_inc;
	logic              forgive;
	logic              force_blk;

	entry_report_t reports_due[$];
	entry_report_t want;
	int n_due = 0;
	int n_fail = 0;

	assign outstanding = n_due;
	assign fail_count  = n_fail;

	// Update the shadow table for one request and return the entry as it should be reported.
	function automatic entry_report_t train_entry(op_t op, logic [PC_W-1:0] pc, logic ld,
			logic al);
		logic [IDX_W-1:0] slot;
		logic [WAIT_W:0]  sum;
		entry_report_t    r;
		slot = pc[IDX_W-1:0];
		r.must_wait  = 1'b0;
		r.wait_count = wait_tbl[slot];
		r.viol_count = viol_tbl[slot];
		case (op)
			OP_PREDICT: begin
				r.must_wait = ld && (force_blk || r.wait_count != '0);
			end
			OP_VIOLATION: begin
				if (r.viol_count < viol_max)
					r.viol_count = r.viol_count + 1'b1;
				r.wait_count = (r.viol_count >= viol_max) ? wait_set : '0;
			end
			OP_RESOLVE: begin
				if (al) begin
					// saturate against the ceiling even when the counter already sits above it
					sum = {1'b0, r.wait_count} + {1'b0, wait_inc};
					r.wait_count = (sum > {1'b0, wait_max}) ? wait_max : sum[WAIT_W-1:0];
				end else if (r.wait_count != '0) begin
					r.wait_count = r.wait_count - 1'b1;
					if (forgive && r.wait_count == '0)
						r.viol_count = '0;
				end
			end
			default: begin
				for (int k = 0; k < ENTRIES; k++) begin
					wait_tbl[k] = '0;
					viol_tbl[k] = '0;
				end
				r.wait_count = '0;
				r.viol_count = '0;
			end
		endcase
		wait_tbl[slot] = r.wait_count;
		viol_tbl[slot] = r.viol_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) begin
				wait_tbl[k] = '0;
				viol_tbl[k] = '0;
			end
			wait_max  = 6'd63;
			viol_max  = 2'd3;
			wait_set  = 6'd15;
			wait_inc  = 6'd1;
			forgive   = 1'b0;
			force_blk = 1'b0;
			reports_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("result %h with no request outstanding", m_tdata);
					n_fail++;
				end else begin
					want = reports_due.pop_front();
					if (m_tdata[0] !== want.must_wait) begin
						$error("must_wait: expected %0d, got %0d", want.must_wait, m_tdata[0]);
						n_fail++;
					end
					if (m_tdata[WAIT_W:1] !== want.wait_count) begin
						$error("wait_count: expected %0d, got %0d", want.wait_count,
							m_tdata[WAIT_W:1]);
						n_fail++;
					end
					if (m_tdata[ENTRY_W:WAIT_W+1] !== want.viol_count) begin
						$error("violation_count: expected %0d, got %0d", want.viol_count,
							m_tdata[ENTRY_W:WAIT_W+1]);
						n_fail++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_WAIT_MAX:    wait_max  = cfg_data[WAIT_W-1:0];
					CFG_VIOL_MAX:    viol_max  = cfg_data[VIOL_W-1:0];
					CFG_WAIT_SET:    wait_set  = cfg_data[WAIT_W-1:0];
					CFG_WAIT_INC:    wait_inc  = cfg_data[WAIT_W-1:0];
					CFG_FORGIVE:     forgive   = cfg_data[0];
					CFG_FORCE_BLOCK: force_blk = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				reports_due.push_back(train_entry(op_t'(s_tuser), s_tdata[PC_W-1:0],
					s_tdata[PC_W], s_tdata[PC_W+1]));
		end
		n_due = reports_due.size();
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the store-bypass predictor table testbench: stimulus, reset, clock and verdict.
`timescale 1ns / 100ps
module tb_top;
	import sbp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    outstanding;
	int                    fail_count;

	logic [IDX_W-1:0] hot_slots [6];
	int               total;
	int               phase_len;
	int               phase;
	bit               steady;

	localparam logic [PC_W-1:0] PC_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [PC_W-1:0] PC_A    = 64'h0000_0000_0000_0005;
	localparam logic [PC_W-1:0] PC_A_HI = 64'hDEAD_0000_0000_0405;
	localparam logic [PC_W-1:0] PC_B    = 64'h0000_0000_0000_0200;
	localparam logic [PC_W-1:0] PC_C    = 64'h0000_0000_0000_0003;
	localparam logic [PC_W-1:0] PC_D    = 64'h0000_0000_0000_0010;
	localparam logic [PC_W-1:0] PC_E    = 64'h8000_0000_0000_0100;
	localparam logic [PC_W-1:0] PC_F    = 64'h0000_0000_0000_0777;

	always #2 clk = ~clk;

	store_bypass_predictor_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sbp_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// Mostly back-to-back, sometimes a short gap, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(op_t op, logic [PC_W-1:0] pc, logic ld, logic al, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_TDATA_W-PC_W-2){1'b0}}, al, ld, pc};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t id, logic [CFG_DATA_W-1:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= id;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic load_settings(logic [5:0] wmax, logic [1:0] vmax, logic [5:0] wset,
			logic [5:0] winc, logic fgv, logic fblk);
		write_reg(CFG_WAIT_MAX, wmax, 1'b0);
		write_reg(CFG_VIOL_MAX, {4'd0, vmax}, 1'b0);
		write_reg(CFG_WAIT_SET, wset, 1'b0);
		write_reg(CFG_WAIT_INC, winc, 1'b0);
		write_reg(CFG_FORGIVE, {5'd0, fgv}, 1'b0);
		write_reg(CFG_FORCE_BLOCK, {5'd0, fblk}, 1'b1);
	endtask

	// Drop valid and hold until every result is back and the block has gone quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_request(int gap);
		int               r;
		op_t              op;
		logic [PC_W-1:0]  pc;
		logic             ld;
		r = $urandom_range(0, 99);
		if (r < 35)
			op = OP_PREDICT;
		else if (r < 60)
			op = OP_VIOLATION;
		else if (r < 98)
			op = OP_RESOLVE;
		else
			op = OP_CLEAR;
		pc = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0)
			pc[IDX_W-1:0] = hot_slots[$urandom_range(0, 5)];
		ld = (op == OP_PREDICT) ? ($urandom_range(0, 4) != 0) : 1'($urandom);
		send_request(op, pc, ld, 1'($urandom), gap);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: build up, alias by low bits, decay
		send_request(OP_PREDICT, '0, 1'b1, 1'b0, pick_gap());
		send_request(OP_PREDICT, PC_ONES, 1'b0, 1'b1, pick_gap());
		repeat (3) send_request(OP_VIOLATION, PC_A, 1'b0, 1'b0, pick_gap());
		send_request(OP_PREDICT, PC_A_HI, 1'b1, 1'b0, pick_gap());
		send_request(OP_RESOLVE, PC_A, 1'b0, 1'b1, pick_gap());
		send_request(OP_RESOLVE, PC_A, 1'b1, 1'b0, pick_gap());
		repeat (3) send_request(OP_VIOLATION, PC_E, 1'b0, 1'b0, pick_gap());
		drain();

		// force block, zero violation ceiling, set value above the wait ceiling
		load_settings(6'd10, 2'd0, 6'd63, 6'd63, 1'b1, 1'b1);
		send_request(OP_PREDICT, PC_A, 1'b0, 1'b0, pick_gap());
		send_request(OP_PREDICT, PC_F, 1'b1, 1'b0, pick_gap());
		send_request(OP_VIOLATION, PC_B, 1'b1, 1'b1, pick_gap());
		send_request(OP_RESOLVE, PC_B, 1'b0, 1'b1, pick_gap());
		send_request(OP_RESOLVE, PC_B, 1'b0, 1'b0, pick_gap());
		send_request(OP_RESOLVE, PC_C, 1'b0, 1'b0, pick_gap());
		drain();

		// violation counter above its ceiling, forgive on decay, clear
		load_settings(6'd0, 2'd1, 6'd1, 6'd0, 1'b1, 1'b0);
		send_request(OP_VIOLATION, PC_E, 1'b0, 1'b0, pick_gap());
		send_request(OP_VIOLATION, PC_D, 1'b0, 1'b0, pick_gap());
		send_request(OP_RESOLVE, PC_D, 1'b0, 1'b0, pick_gap());
		send_request(OP_RESOLVE, PC_D, 1'b0, 1'b1, pick_gap());
		send_request(OP_PREDICT, PC_E, 1'b1, 1'b0, pick_gap());
		send_request(OP_CLEAR, PC_ONES, 1'b1, 1'b1, pick_gap());
		send_request(OP_PREDICT, PC_E, 1'b1, 1'b0, pick_gap());
		drain();

		total = 0;
		phase = 0;
		while (total < 850) begin
			case (phase)
				0: load_settings(6'd63, 2'd3, 6'd63, 6'd63, 1'b1, 1'b1);
				1: load_settings(6'd0, 2'd0, 6'd0, 6'd0, 1'b0, 1'b0);
				2: load_settings(6'd63, 2'd3, 6'd15, 6'd1, 1'b0, 1'b0);
				default: load_settings(6'($urandom), 2'($urandom), 6'($urandom),
					6'($urandom_range(0, 8)), 1'($urandom), 1'($urandom_range(0, 4) == 0));
			endcase
			// keep traffic on a few entries so the counters train deep
			foreach (hot_slots[i])
				hot_slots[i] = IDX_W'($urandom);
			if (phase % 3 == 0)
				hot_slots[0] = '1;
			if (phase % 3 == 1)
				hot_slots[1] = '0;
			steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(60, 110);
			repeat (phase_len)
				random_request(steady ? 0 : pick_gap());
			total += phase_len;
			phase++;
			drain();
		end

		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result backpressure: stretches always ready, stretches with random stalls.
	initial begin
		int run;
		int stall;
		forever begin
			run = $urandom_range(10, 80);
			if ($urandom_range(0, 2) == 0) begin
				repeat (run) begin
					@(negedge clk);
					m_tready <= 1'b1;
				end
			end else begin
				repeat (run) begin
					@(negedge clk);
					m_tready <= 1'b1;
					stall = pick_gap();
					repeat (stall) begin
						@(negedge clk);
						m_tready <= 1'b0;
					end
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sbp_pkg.sv
hdl/sbp_ram.sv
hdl/sbp_dp.sv
hdl/sbp_ctrl.sv
hdl/store_bypass_predictor_table_top.sv
test/sbp_checker.sv
test/tb_top.sv
